// ===== hw/rtl/rcr_pkg.sv =====
// Shared constants, operation codes and the sweep setup structure of the rectangle rasterizer.
package rcr_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int FRAC_BITS  = 8;

	localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ADDR_W   = ROW_BITS + COL_BITS;

	localparam int FIELD_W = 24;
	localparam int CHAR_W  = 8;
	localparam int SIZE_W  = 9;
	localparam int IDX_W   = 2;
	localparam int COORD_W = FIELD_W + 3;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_FILL    = 2'd1;
	localparam logic [1:0] OP_OUTLINE = 2'd2;
	localparam logic [1:0] OP_READ    = 2'd3;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_BG     = 2'd2;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_SIZE = 1'b1;

	typedef struct packed {
		logic                       clear;
		logic                       outline;
		logic [CHAR_W-1:0]          char_val;
		logic [COL_BITS-1:0]        col_last;
		logic [ROW_BITS-1:0]        row_last;
		logic signed [COORD_W-1:0]  x_lo;
		logic signed [COORD_W-1:0]  x_hi;
		logic signed [COORD_W-1:0]  x_in;
		logic signed [COORD_W-1:0]  x_ih;
		logic signed [COORD_W-1:0]  y_lo;
		logic signed [COORD_W-1:0]  y_hi;
		logic signed [COORD_W-1:0]  y_in;
		logic signed [COORD_W-1:0]  y_ih;
	} sweep_cfg_t;

	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   addr;
		logic [CHAR_W-1:0]   data;
	} wr_req_t;

endpackage

// ===== hw/rtl/rcr_ram.sv =====
// Generic memory with one write port and one read port whose read data is registered.
module rcr_ram #(
	parameter int AW = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1 << AW) - 1];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/rcr_sweep.sv =====
// Raster sweep of the canvas in use: decides coverage of one pixel a cycle and writes hits.
module rcr_sweep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rcr_pkg::sweep_cfg_t cfg_in,
	output rcr_pkg::wr_req_t   wr,
	output logic               done
);
	import rcr_pkg::*;

	sweep_cfg_t                cfg_q;
	logic                      busy_q;
	logic [COL_BITS-1:0]       col_q;
	logic [ROW_BITS-1:0]       row_q;
	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic                      covered;
	logic                      edge_hit;
	logic                      hit;
	logic                      col_end;
	logic                      last;
	logic                      we_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic [CHAR_W-1:0]         data_s1;
	logic                      last_s1;

	assign px = signed'(COORD_W'(col_q) << FRAC_BITS);
	assign py = signed'(COORD_W'(row_q) << FRAC_BITS);

	assign covered = (px >= cfg_q.x_lo) && (px <= cfg_q.x_hi) &&
		(py >= cfg_q.y_lo) && (py <= cfg_q.y_hi);
	assign edge_hit = (px < cfg_q.x_in) || (py < cfg_q.y_in) ||
		(px > cfg_q.x_ih) || (py > cfg_q.y_ih);
	assign hit = cfg_q.clear || (covered && (!cfg_q.outline || edge_hit));

	assign col_end = (col_q == cfg_q.col_last);
	assign last    = col_end && (row_q == cfg_q.row_last);

	always_ff @(posedge clk) begin
		if (start) begin
			cfg_q <= cfg_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
			we_s1   <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			we_s1   <= busy_q && hit;
			last_s1 <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				col_q  <= '0;
				row_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {row_q, col_q};
		data_s1 <= cfg_q.char_val;
	end

	assign wr.we   = we_s1;
	assign wr.addr = addr_s1;
	assign wr.data = data_s1;
	assign done    = last_s1;

endmodule

// ===== hw/rtl/rectangle_canvas_rasterizer_top.sv =====
// Top level of the rectangle canvas rasterizer: stream ports, registers, control and canvas memory.
//
// The canvas is held in one memory of MAX_WIDTH by MAX_HEIGHT characters with a registered
// read. A clear, filled-rectangle or outline item walks the whole canvas in use, one pixel
// per cycle, through the states SWEEP and DONE; a read item passes through READ and DONE, and
// a draw with a width or height that is not positive goes straight to DONE. One item is worked
// on at a time; the next transfer is accepted as soon as the result has moved into the
// output register. The canvas has no defined contents after reset, so a clear must come
// before any pixel is read.
module rectangle_canvas_rasterizer_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rcr_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rcr_pkg::SIZE_W-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// rect_x, rect_y, rect_w, rect_h, paint_char, read_row, read_col
	input  logic [119:0]             s_tdata,
	// opcode
	input  logic [1:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// pixel_char
	output logic [7:0]               m_tdata,
	// status
	output logic                     m_tuser
);
	import rcr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SWEEP = 4'b0010,
		ST_READ  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [SIZE_W-1:0]          width_q;
	logic [SIZE_W-1:0]          height_q;
	logic [CHAR_W-1:0]          bg_q;

	logic                       accept;
	logic [1:0]                 opcode;
	logic signed [FIELD_W-1:0]  rect_x;
	logic signed [FIELD_W-1:0]  rect_y;
	logic signed [FIELD_W-1:0]  rect_w;
	logic signed [FIELD_W-1:0]  rect_h;
	logic [CHAR_W-1:0]          paint_char;
	logic [7:0]                 read_row;
	logic [7:0]                 read_col;

	logic [COL_BITS-1:0]        col_last;
	logic [ROW_BITS-1:0]        row_last;
	logic                       size_bad;
	logic                       read_ok;
	logic                       sweep_start;
	sweep_cfg_t                 sweep_cfg;
	wr_req_t                    wr;
	logic                       sweep_done;
	logic                       rd_en;
	logic [ADDR_W-1:0]          rd_addr;
	logic [CHAR_W-1:0]          rd_data;

	logic                       read_ok_q;
	logic                       res_status_q;
	logic [CHAR_W-1:0]          res_pix_q;
	logic                       m_tvalid_q;
	logic                       m_status_q;
	logic [CHAR_W-1:0]          m_pix_q;
	logic                       out_free;

	assign opcode     = s_tuser;
	assign rect_x     = s_tdata[23:0];
	assign rect_y     = s_tdata[47:24];
	assign rect_w     = s_tdata[71:48];
	assign rect_h     = s_tdata[95:72];
	assign paint_char = s_tdata[103:96];
	assign read_row   = s_tdata[111:104];
	assign read_col   = s_tdata[119:112];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		if (width_q == '0) begin
			col_last = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			col_last = COL_BITS'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_BITS'(width_q - 1'b1);
		end
		if (height_q == '0) begin
			row_last = '0;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			row_last = ROW_BITS'(MAX_HEIGHT - 1);
		end else begin
			row_last = ROW_BITS'(height_q - 1'b1);
		end
	end

	assign size_bad = rect_w[FIELD_W-1] || (rect_w == '0) ||
		rect_h[FIELD_W-1] || (rect_h == '0);
	assign read_ok = (int'(read_row) <= int'(row_last)) &&
		(int'(read_col) <= int'(col_last));

	assign sweep_start = accept && ((opcode == OP_CLEAR) ||
		((opcode == OP_FILL || opcode == OP_OUTLINE) && !size_bad));

	always_comb begin
		sweep_cfg.clear    = (opcode == OP_CLEAR);
		sweep_cfg.outline  = (opcode == OP_OUTLINE);
		sweep_cfg.char_val = (opcode == OP_CLEAR) ? bg_q : paint_char;
		sweep_cfg.col_last = col_last;
		sweep_cfg.row_last = row_last;
		sweep_cfg.x_lo     = COORD_W'(rect_x);
		sweep_cfg.x_hi     = COORD_W'(rect_x) + COORD_W'(rect_w);
		sweep_cfg.x_in     = COORD_W'(rect_x) + (COORD_W'(1) << FRAC_BITS);
		sweep_cfg.x_ih     = COORD_W'(rect_x) + COORD_W'(rect_w) - (COORD_W'(1) << FRAC_BITS);
		sweep_cfg.y_lo     = COORD_W'(rect_y);
		sweep_cfg.y_hi     = COORD_W'(rect_y) + COORD_W'(rect_h);
		sweep_cfg.y_in     = COORD_W'(rect_y) + (COORD_W'(1) << FRAC_BITS);
		sweep_cfg.y_ih     = COORD_W'(rect_y) + COORD_W'(rect_h) - (COORD_W'(1) << FRAC_BITS);
	end

	assign rd_en   = accept && (opcode == OP_READ);
	assign rd_addr = {ROW_BITS'(read_row), COL_BITS'(read_col)};

	rcr_sweep u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sweep_start),
		.cfg_in (sweep_cfg),
		.wr     (wr),
		.done   (sweep_done)
	);

	rcr_ram #(
		.AW (ADDR_W),
		.DW (CHAR_W)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
			bg_q     <= CHAR_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_BG:     bg_q     <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sweep_start) begin
							state_q <= ST_SWEEP;
						end else if (opcode == OP_READ) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_ok_q    <= read_ok;
			res_status_q <= (opcode == OP_FILL || opcode == OP_OUTLINE) && size_bad ?
				STATUS_BAD_SIZE : STATUS_OK;
			res_pix_q    <= '0;
		end else if (state_q == ST_READ) begin
			res_pix_q <= read_ok_q ? rd_data : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_pix_q    <= res_pix_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_pix_q;
	assign m_tuser  = m_status_q;

endmodule

// ===== verif/tb_rectangle_canvas_rasterizer_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the rectangle canvas rasterizer with a canvas predictor and scoreboard.

typedef struct packed {
	logic [7:0]         read_col;
	logic [7:0]         read_row;
	logic [7:0]         paint_char;
	logic signed [23:0] rect_h;
	logic signed [23:0] rect_w;
	logic signed [23:0] rect_y;
	logic signed [23:0] rect_x;
} canvas_item_t;

typedef struct {
	logic       status;
	logic [7:0] pixel_char;
} canvas_reply_t;

class canvas_shadow;
	logic [7:0]    pixels [rcr_pkg::MAX_WIDTH * rcr_pkg::MAX_HEIGHT];
	logic [8:0]    width_reg;
	logic [8:0]    height_reg;
	logic [7:0]    bg_char;
	canvas_reply_t replies_due[$];
	int unsigned   mismatches;

	function new();
		width_reg  = 9'd256;
		height_reg = 9'd256;
		bg_char    = 8'd32;
		mismatches = 0;
	endfunction

	function int columns();
		if (width_reg == 0)
			return 1;
		if (width_reg > rcr_pkg::MAX_WIDTH)
			return rcr_pkg::MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function int rows();
		if (height_reg == 0)
			return 1;
		if (height_reg > rcr_pkg::MAX_HEIGHT)
			return rcr_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function void write_reg(logic [rcr_pkg::IDX_W-1:0] idx, logic [8:0] value);
		case (idx)
			rcr_pkg::REG_WIDTH:  width_reg = value;
			rcr_pkg::REG_HEIGHT: height_reg = value;
			rcr_pkg::REG_BG:     bg_char = value[7:0];
			default: ;
		endcase
	endfunction

	function void note_item(logic [1:0] op, canvas_item_t it);
		canvas_reply_t reply;
		int cw;
		int ch;
		longint x;
		longint y;
		longint w;
		longint h;
		longint px;
		longint py;
		longint unit_len;
		bit near_edge;
		cw = columns();
		ch = rows();
		reply.status = rcr_pkg::STATUS_OK;
		reply.pixel_char = 8'd0;
		x = it.rect_x;
		y = it.rect_y;
		w = it.rect_w;
		h = it.rect_h;
		unit_len = longint'(1) << rcr_pkg::FRAC_BITS;
		case (op)
			rcr_pkg::OP_CLEAR: begin
				for (int r = 0; r < ch; r++)
					for (int c = 0; c < cw; c++)
						pixels[r * rcr_pkg::MAX_WIDTH + c] = bg_char;
			end
			rcr_pkg::OP_READ: begin
				if (int'(it.read_row) < ch && int'(it.read_col) < cw)
					reply.pixel_char =
						pixels[int'(it.read_row) * rcr_pkg::MAX_WIDTH + int'(it.read_col)];
			end
			default: begin
				if (w <= 0 || h <= 0) begin
					reply.status = rcr_pkg::STATUS_BAD_SIZE;
				end else begin
					for (int r = 0; r < ch; r++) begin
						py = longint'(r) * unit_len;
						if (py >= y && py <= y + h) begin
							for (int c = 0; c < cw; c++) begin
								px = longint'(c) * unit_len;
								if (px >= x && px <= x + w) begin
									near_edge = (px - x < unit_len) || (py - y < unit_len) ||
										(x + w - px < unit_len) || (y + h - py < unit_len);
									if (op == rcr_pkg::OP_FILL || near_edge)
										pixels[r * rcr_pkg::MAX_WIDTH + c] = it.paint_char;
								end
							end
						end
					end
				end
			end
		endcase
		replies_due.push_back(reply);
	endfunction

	function void check_result(logic status, logic [7:0] pixel_char);
		canvas_reply_t due;
		if (replies_due.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result, expected none, actual status %0d pixel_char 0x%02h",
				$time, status, pixel_char);
			return;
		end
		due = replies_due.pop_front();
		if (status !== due.status) begin
			mismatches++;
			$display("%0t: status mismatch, expected %0d, actual %0d", $time, due.status, status);
		end
		if (pixel_char !== due.pixel_char) begin
			mismatches++;
			$display("%0t: pixel_char mismatch, expected 0x%02h, actual 0x%02h",
				$time, due.pixel_char, pixel_char);
		end
	endfunction
endclass

module tb_rectangle_canvas_rasterizer_top;

	localparam int QUIET_LIMIT = 250000;
	localparam int HOLD_CYCLES = 2000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [rcr_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [rcr_pkg::SIZE_W-1:0] cfg_data = '0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [119:0]               s_tdata = '0;
	logic [1:0]                 s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [7:0]                 m_tdata;
	logic                       m_tuser;

	canvas_shadow shadow = new();
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;
	int hold_left = 0;

	rectangle_canvas_rasterizer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic canvas_item_t make_item(int x, int y, int w, int h, int paint,
		int row = 0, int col = 0);
		canvas_item_t it;
		it.rect_x     = x[23:0];
		it.rect_y     = y[23:0];
		it.rect_w     = w[23:0];
		it.rect_h     = h[23:0];
		it.paint_char = paint[7:0];
		it.read_row   = row[7:0];
		it.read_col   = col[7:0];
		return it;
	endfunction

	function automatic logic [23:0] near_coord(input int cells);
		int v;
		v = int'($urandom_range((cells + 6) * 256)) - 3 * 256;
		return v[23:0];
	endfunction

	function automatic logic [23:0] span_len(input int cells);
		int v;
		if ($urandom_range(3) == 0)
			v = int'($urandom_range(1, 512));
		else
			v = int'($urandom_range(1, (cells + 2) * 256));
		return v[23:0];
	endfunction

	task automatic set_reg(input logic [rcr_pkg::IDX_W-1:0] idx, input logic [8:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow.write_reg(idx, value);
	endtask

	task automatic set_canvas(input logic [8:0] cols, input logic [8:0] rows,
		input logic [7:0] bg);
		set_reg(rcr_pkg::REG_WIDTH, cols);
		set_reg(rcr_pkg::REG_HEIGHT, rows);
		set_reg(rcr_pkg::REG_BG, {1'b0, bg});
	endtask

	task automatic send_item(input logic [1:0] op, input canvas_item_t it);
		@(negedge clk);
		while (sender_gaps && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= it;
		do @(posedge clk); while (!s_tready);
		shadow.note_item(op, it);
	endtask

	task automatic send_read(input int row, input int col);
		send_item(rcr_pkg::OP_READ, make_item(0, 0, 0, 0, 0, row, col));
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (shadow.replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_run(input int count);
		int cols;
		int rows;
		int pick;
		int bad;
		logic [127:0] noise;
		canvas_item_t it;
		logic [1:0] op;
		cols = shadow.columns();
		rows = shadow.rows();
		send_item(rcr_pkg::OP_CLEAR, make_item(0, 0, 0, 0, 0));
		for (int i = 0; i < count; i++) begin
			noise = {$urandom(), $urandom(), $urandom(), $urandom()};
			it = noise[119:0];
			pick = $urandom_range(99);
			op = $urandom_range(1) ? rcr_pkg::OP_FILL : rcr_pkg::OP_OUTLINE;
			if (pick < 4) begin
				op = rcr_pkg::OP_CLEAR;
			end else if (pick < 38) begin
				op = rcr_pkg::OP_READ;
				if (pick < 34) begin
					it.read_row = 8'($urandom_range(rows - 1));
					it.read_col = 8'($urandom_range(cols - 1));
				end
			end else if (pick < 90) begin
				it.rect_x = near_coord(cols);
				it.rect_y = near_coord(rows);
				it.rect_w = span_len(cols);
				it.rect_h = span_len(rows);
				if (pick >= 84) begin
					bad = -int'($urandom_range(600));
					if ($urandom_range(1))
						it.rect_w = bad[23:0];
					else
						it.rect_h = bad[23:0];
				end
			end
			send_item(op, it);
		end
	endtask

	initial begin : result_sink
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !(receiver_stalls && $urandom_range(99) < 17);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			shadow.check_result(m_tuser, m_tdata);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, quiet);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// A width register of zero acts as one column.
		set_canvas(9'd0, 9'd1, 8'hFF);
		send_item(rcr_pkg::OP_CLEAR, make_item(0, 0, 0, 0, 0));
		send_read(0, 0);
		send_item(rcr_pkg::OP_FILL, make_item(-8388608, -8388608, 8388607, 8388607, 8'h00));
		send_read(0, 0);
		send_item(rcr_pkg::OP_FILL, make_item(0, 0, 1, 1, 8'hA5));
		send_read(0, 0);
		send_read(0, 1);
		send_read(255, 255);
		drain();

		set_canvas(9'd16, 9'd12, 8'h00);
		send_item(rcr_pkg::OP_CLEAR, make_item(0, 0, 0, 0, 0));
		send_item(rcr_pkg::OP_OUTLINE, make_item('h180, 'h080, 'hA00, 'h800, "R"));
		send_item(rcr_pkg::OP_FILL, make_item('h300, 'h200, 'h280, 'h100, "r"));
		send_item(rcr_pkg::OP_OUTLINE, make_item('hA40, 'h080, 'h080, 'h500, 8'h7E));
		send_item(rcr_pkg::OP_FILL, make_item('h100, 'h100, 0, 'h100, 8'h55));
		send_item(rcr_pkg::OP_OUTLINE, make_item('h100, 'h100, 'h100, -8388608, 8'h55));
		send_item(rcr_pkg::OP_FILL, make_item(0, 0, -1, -1, 8'h55));
		send_read(1, 2);
		send_read(2, 3);
		send_read(5, 10);
		send_read(11, 15);
		send_read(12, 0);
		drain();

		// A width register above the maximum acts as the maximum.
		set_canvas(9'h1FF, 9'd256, 8'h2E);
		send_item(rcr_pkg::OP_CLEAR, make_item(0, 0, 0, 0, 0));
		send_item(rcr_pkg::OP_OUTLINE, make_item(-'h80, 'h100, 'hFF00, 8388607, 8'h23));
		send_item(rcr_pkg::OP_FILL, make_item('h8000, 'h4000, 'h200, 'h300, 8'h40));
		send_read(0, 0);
		send_read(255, 255);
		send_read(64, 129);
		drain();

		set_canvas(9'd1, 9'd300, 8'($urandom));
		random_run(18);
		drain();

		set_canvas(9'($urandom_range(2, 24)), 9'($urandom_range(2, 24)), 8'($urandom));
		hold_left = HOLD_CYCLES;
		random_run(18);
		drain();

		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		set_canvas(9'($urandom_range(2, 24)), 9'($urandom_range(2, 24)), 8'($urandom));
		random_run(18);
		drain();

		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		set_canvas(9'd256, 9'd0, 8'h00);
		random_run(18);
		drain();

		repeat (8) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
